FILE: sv/dd_pi_pkg.sv
// Shared constants, types and state encoding for the wheel speed PI controller.
package dd_pi_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int SUM_WIDTH  = 32;

    localparam int GAIN_W  = 10;
    localparam int DIST_W  = 10;
    localparam int HTRK_W  = 12;
    localparam int SCALE_W = 16;
    localparam int LIM_W   = 8;
    localparam int MS_W    = 16;
    localparam int SPD_W   = 16;
    localparam int MODE_W  = 2;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int REG_W   = 3;

    localparam int SPEED_SHIFT = 16 - FRAC_BITS;
    localparam int NUM_W  = TICK_WIDTH + SCALE_W + 1;
    localparam int MAG_W  = TICK_WIDTH + SCALE_W - 1;
    localparam int DEN_W  = MS_W + SPEED_SHIFT;
    localparam int DCNT_W = $clog2(MAG_W + 1);
    localparam int HP_W   = HTRK_W + 1 + SPD_W;
    localparam int HT_W   = HP_W - FRAC_BITS;
    localparam int SP_W   = ((HT_W > SPD_W) ? HT_W : SPD_W) + 1;
    localparam int ERR_W  = SP_W + 1;
    localparam int SADD_W = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
    localparam int PE_W   = ERR_W + GAIN_W + 1;
    localparam int IS_W   = SUM_WIDTH + GAIN_W + 1;
    localparam int U_W    = ((PE_W > IS_W) ? PE_W : IS_W) + 1;
    localparam int SH_W   = U_W - FRAC_BITS;
    localparam int DRV_W  = LIM_W + 1;

    localparam int SPEED_POS_MAX = 2 ** (SPD_W - 1) - 1;
    localparam int SPEED_NEG_MAG = 2 ** (SPD_W - 1);

    localparam logic signed [TICK_WIDTH-1:0] TICK_MAX = {1'b0, {(TICK_WIDTH - 1){1'b1}}};
    localparam logic signed [TICK_WIDTH-1:0] TICK_MIN = {1'b1, {(TICK_WIDTH - 1){1'b0}}};
    localparam logic signed [SUM_WIDTH-1:0]  SUM_MAX  = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0]  SUM_MIN  = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
    localparam logic signed [SPD_W-1:0]      SPD_MAX  = {1'b0, {(SPD_W - 1){1'b1}}};
    localparam logic signed [SPD_W-1:0]      SPD_MIN  = {1'b1, {(SPD_W - 1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [REG_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [REG_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [REG_W-1:0] REG_OBST_THRESH = 3'd2;
    localparam logic [REG_W-1:0] REG_HALF_TRACK  = 3'd3;
    localparam logic [REG_W-1:0] REG_SPEED_SCALE = 3'd4;
    localparam logic [REG_W-1:0] REG_DRIVE_LIMIT = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 10'd250;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 10'd125;
    localparam logic [DIST_W-1:0]  RST_OBST_THRESH = 10'd30;
    localparam logic [HTRK_W-1:0]  RST_HALF_TRACK  = 12'd568;
    localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 16'd8579;
    localparam logic [LIM_W-1:0]   RST_DRIVE_LIMIT = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SPD,
        ST_ERR,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic edge_left;
        logic edge_right;
        logic tick_start;
        logic div_start;
        logic spd_step;
        logic err_step;
        logic mul_step;
        logic acc_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: sv/dd_pi_div.sv
// Restoring serial divider, one quotient bit per cycle.
module dd_pi_div import dd_pi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [MAG_W-1:0]  r_quo;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;

    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem <= w_diff[DEN_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sv/dd_pi_dp.sv
// Datapath: tick counters, speed measurement, setpoints and the two PI lanes.
module dd_pi_dp import dd_pi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_b_level,
    input  logic [MS_W-1:0]        i_elapsed_ms,
    input  logic [DIST_W-1:0]      i_ir_distance,
    input  logic signed [SPD_W-1:0] i_desired_speed,
    input  logic signed [SPD_W-1:0] i_turn_rate,
    input  logic [GAIN_W-1:0]      i_prop_gain,
    input  logic [GAIN_W-1:0]      i_integ_gain,
    input  logic [DIST_W-1:0]      i_obstacle_threshold,
    input  logic [HTRK_W-1:0]      i_half_track,
    input  logic [SCALE_W-1:0]     i_speed_scale,
    input  logic [LIM_W-1:0]       i_drive_limit,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [LIM_W-1:0]       o_left_duty,
    output logic                   o_left_reverse,
    output logic [LIM_W-1:0]       o_right_duty,
    output logic                   o_right_reverse,
    output logic                   o_buzzer_on,
    output logic signed [SPD_W-1:0] o_left_speed,
    output logic signed [SPD_W-1:0] o_right_speed
);

    // lane 0 is the left wheel, lane 1 the right
    logic signed [TICK_WIDTH-1:0] r_tick  [2];
    logic signed [NUM_W-1:0]      r_num   [2];
    logic                         r_neg   [2];
    logic signed [SP_W-1:0]       r_sp    [2];
    logic signed [SPD_W-1:0]      r_speed [2];
    logic signed [ERR_W-1:0]      r_err   [2];
    logic signed [SUM_WIDTH-1:0]  r_sum   [2];
    logic signed [PE_W-1:0]       r_pe    [2];
    logic signed [IS_W-1:0]       r_is    [2];
    logic signed [DRV_W-1:0]      r_last  [2];
    logic [DEN_W-1:0]             r_den;
    logic signed [HT_W-1:0]       r_ht;
    logic signed [SPD_W-1:0]      r_v;
    logic                         r_buzz;

    logic                         r_out_valid;
    logic [LIM_W-1:0]             r_out_duty  [2];
    logic                         r_out_rev   [2];
    logic signed [SPD_W-1:0]      r_out_speed [2];
    logic                         r_out_buzz;

    logic signed [TICK_WIDTH-1:0] w_tick_nxt [2];
    logic                         w_up       [2];
    logic signed [NUM_W-1:0]      w_num      [2];
    logic [MAG_W-1:0]             w_mag      [2];
    logic [MAG_W-1:0]             w_quo      [2];
    logic                         w_done     [2];
    logic signed [SPD_W-1:0]      w_speed    [2];
    logic signed [ERR_W-1:0]      w_err      [2];
    logic signed [SADD_W-1:0]     w_sadd     [2];
    logic signed [SUM_WIDTH-1:0]  w_sum_sat  [2];
    logic [DRV_W-1:0]             w_dmag     [2];
    logic                         w_integ    [2];
    logic signed [U_W-1:0]        w_acc      [2];
    logic signed [SH_W-1:0]       w_sh       [2];
    logic signed [SH_W-1:0]       w_drv      [2];
    logic signed [HP_W-1:0]       w_hp;
    logic signed [SH_W-1:0]       w_lim;
    logic [DEN_W-1:0]             w_den;
    logic [MS_W-1:0]              w_ms;
    logic                         w_buzz;

    assign w_up[0] = i_b_level;
    assign w_up[1] = !i_b_level;

    assign w_ms   = (i_elapsed_ms == '0) ? MS_W'(1) : i_elapsed_ms;
    assign w_den  = DEN_W'(w_ms) << SPEED_SHIFT;
    assign w_hp   = signed'({1'b0, i_half_track}) * i_turn_rate;
    assign w_buzz = (i_ir_distance < i_obstacle_threshold) && (i_desired_speed > 0);
    assign w_lim  = signed'(SH_W'(i_drive_limit));

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (w_up[k]) begin
                w_tick_nxt[k] = (r_tick[k] == TICK_MAX) ? r_tick[k] : r_tick[k] + TICK_WIDTH'(1);
            end else begin
                w_tick_nxt[k] = (r_tick[k] == TICK_MIN) ? r_tick[k] : r_tick[k] - TICK_WIDTH'(1);
            end
            w_num[k] = r_tick[k] * signed'({1'b0, i_speed_scale});
            w_mag[k] = r_num[k][NUM_W-1] ? MAG_W'(-r_num[k]) : MAG_W'(r_num[k]);

            if (r_neg[k]) begin
                w_speed[k] = (w_quo[k] >= MAG_W'(SPEED_NEG_MAG)) ? SPD_MIN
                                                                 : -signed'(SPD_W'(w_quo[k]));
            end else begin
                w_speed[k] = (w_quo[k] > MAG_W'(SPEED_POS_MAX)) ? SPD_MAX
                                                                : signed'(SPD_W'(w_quo[k]));
            end

            w_err[k]  = ERR_W'(r_sp[k]) - ERR_W'(r_speed[k]);
            w_sadd[k] = SADD_W'(r_sum[k]) + SADD_W'(w_err[k]);
            if (w_sadd[k] > SADD_W'(SUM_MAX)) begin
                w_sum_sat[k] = SUM_MAX;
            end else if (w_sadd[k] < SADD_W'(SUM_MIN)) begin
                w_sum_sat[k] = SUM_MIN;
            end else begin
                w_sum_sat[k] = SUM_WIDTH'(w_sadd[k]);
            end
            w_dmag[k]  = r_last[k][DRV_W-1] ? DRV_W'(-r_last[k]) : DRV_W'(r_last[k]);
            w_integ[k] = w_dmag[k] < {1'b0, i_drive_limit};

            w_acc[k] = U_W'(r_pe[k]) + U_W'(r_is[k]);
            w_sh[k]  = w_acc[k][U_W-1:FRAC_BITS];
            if (w_sh[k] > w_lim) begin
                w_drv[k] = w_lim;
            end else if (w_sh[k] < -w_lim) begin
                w_drv[k] = -w_lim;
            end else begin
                w_drv[k] = w_sh[k];
            end
        end
    end

    dd_pi_div u_div_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag[0]),
        .i_divisor  (r_den),
        .o_done     (w_done[0]),
        .o_quotient (w_quo[0])
    );

    dd_pi_div u_div_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag[1]),
        .i_divisor  (r_den),
        .o_done     (w_done[1]),
        .o_quotient (w_quo[1])
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_tick[k] <= '0;
                r_sum[k]  <= '0;
                r_last[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_start) begin
                r_tick[0] <= '0;
                r_tick[1] <= '0;
            end else begin
                if (i_cmd.edge_left) begin
                    r_tick[0] <= w_tick_nxt[0];
                end
                if (i_cmd.edge_right) begin
                    r_tick[1] <= w_tick_nxt[1];
                end
            end
            for (int k = 0; k < 2; k++) begin
                if (i_cmd.err_step && w_integ[k]) begin
                    r_sum[k] <= w_sum_sat[k];
                end
                if (i_cmd.acc_step) begin
                    r_last[k] <= DRV_W'(w_drv[k]);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_num[0] <= w_num[0];
            r_num[1] <= w_num[1];
            r_den    <= w_den;
            r_ht     <= w_hp[HP_W-1:FRAC_BITS];
            r_v      <= w_buzz ? '0 : i_desired_speed;
            r_buzz   <= w_buzz;
        end
        if (i_cmd.div_start) begin
            r_sp[0]  <= SP_W'(r_v) - SP_W'(r_ht);
            r_sp[1]  <= SP_W'(r_v) + SP_W'(r_ht);
            r_neg[0] <= r_num[0][NUM_W-1];
            r_neg[1] <= r_num[1][NUM_W-1];
        end
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.spd_step) begin
                r_speed[k] <= w_speed[k];
            end
            if (i_cmd.err_step) begin
                r_err[k] <= w_err[k];
            end
            if (i_cmd.mul_step) begin
                r_pe[k] <= signed'({1'b0, i_prop_gain}) * r_err[k];
                r_is[k] <= signed'({1'b0, i_integ_gain}) * r_sum[k];
            end
            if (i_cmd.out_load) begin
                r_out_duty[k]  <= w_dmag[k][LIM_W-1:0];
                r_out_rev[k]   <= r_last[k][DRV_W-1];
                r_out_speed[k] <= r_speed[k];
            end
        end
        if (i_cmd.out_load) begin
            r_out_buzz <= r_buzz;
        end
    end

    assign o_stat.div_done = w_done[0] && w_done[1];
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_left_duty     = r_out_duty[0];
    assign o_left_reverse  = r_out_rev[0];
    assign o_right_duty    = r_out_duty[1];
    assign o_right_reverse = r_out_rev[1];
    assign o_buzzer_on     = r_out_buzz;
    assign o_left_speed    = r_out_speed[0];
    assign o_right_speed   = r_out_speed[1];

endmodule

FILE: sv/dd_pi_ctrl.sv
// Controller state machine sequencing one control tick through the datapath.
module dd_pi_ctrl import dd_pi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_stat          i_stat,
    output logic              o_in_stall,
    output t_dp_cmd           o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_mode == MODE_TICK)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_SPD;
                end
            end
            ST_SPD: n_state = ST_ERR;
            ST_ERR: n_state = ST_MUL;
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != ST_IDLE);
        o_cmd.edge_left  = w_accept && (i_mode == MODE_LEFT);
        o_cmd.edge_right = w_accept && (i_mode == MODE_RIGHT);
        o_cmd.tick_start = w_accept && (i_mode == MODE_TICK);
        o_cmd.div_start  = (r_state == ST_LOAD);
        o_cmd.spd_step   = (r_state == ST_SPD);
        o_cmd.err_step   = (r_state == ST_ERR);
        o_cmd.mul_step   = (r_state == ST_MUL);
        o_cmd.acc_step   = (r_state == ST_ACC);
        o_cmd.out_load   = (r_state == ST_OUT) && !i_stat.out_busy;
    end

endmodule

FILE: sv/diff_drive_wheel_pi_controller_top.sv
// Top level: APB register file, controller and datapath of the wheel speed PI controller.
// Encoder edge transactions are accepted back to back.
// A control tick transaction steps through LOAD, DIV, SPD, ERR, MUL, ACC and OUT; the
// 31-step serial speed dividers run in DIV, and the next transaction is taken in IDLE.
// A waiting result holds the block only if it is still stalled when the next one is ready.
// Synchronous active-low reset clears counters, error sums, last drives; resets registers.
module diff_drive_wheel_pi_controller_top import dd_pi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic                    i_b_level,
    input  logic [MS_W-1:0]         i_elapsed_ms,
    input  logic [DIST_W-1:0]       i_ir_distance,
    input  logic signed [SPD_W-1:0] i_desired_speed,
    input  logic signed [SPD_W-1:0] i_turn_rate,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LIM_W-1:0]        o_left_duty,
    output logic                    o_left_reverse,
    output logic [LIM_W-1:0]        o_right_duty,
    output logic                    o_right_reverse,
    output logic                    o_buzzer_on,
    output logic signed [SPD_W-1:0] o_left_speed,
    output logic signed [SPD_W-1:0] o_right_speed
);

    logic [GAIN_W-1:0]  r_prop_gain;
    logic [GAIN_W-1:0]  r_integ_gain;
    logic [DIST_W-1:0]  r_obstacle_threshold;
    logic [HTRK_W-1:0]  r_half_track;
    logic [SCALE_W-1:0] r_speed_scale;
    logic [LIM_W-1:0]   r_drive_limit;
    logic [REG_W-1:0]   w_reg;
    logic               w_wr;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;

    assign pready = 1'b1;
    assign w_reg  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain          <= RST_PROP_GAIN;
            r_integ_gain         <= RST_INTEG_GAIN;
            r_obstacle_threshold <= RST_OBST_THRESH;
            r_half_track         <= RST_HALF_TRACK;
            r_speed_scale        <= RST_SPEED_SCALE;
            r_drive_limit        <= RST_DRIVE_LIMIT;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_PROP_GAIN:   r_prop_gain          <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_integ_gain         <= pwdata[GAIN_W-1:0];
                REG_OBST_THRESH: r_obstacle_threshold <= pwdata[DIST_W-1:0];
                REG_HALF_TRACK:  r_half_track         <= pwdata[HTRK_W-1:0];
                REG_SPEED_SCALE: r_speed_scale        <= pwdata[SCALE_W-1:0];
                REG_DRIVE_LIMIT: r_drive_limit        <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PROP_GAIN:   prdata = DATA_W'(r_prop_gain);
            REG_INTEG_GAIN:  prdata = DATA_W'(r_integ_gain);
            REG_OBST_THRESH: prdata = DATA_W'(r_obstacle_threshold);
            REG_HALF_TRACK:  prdata = DATA_W'(r_half_track);
            REG_SPEED_SCALE: prdata = DATA_W'(r_speed_scale);
            REG_DRIVE_LIMIT: prdata = DATA_W'(r_drive_limit);
            default:         prdata = '0;
        endcase
    end

    dd_pi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    dd_pi_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_b_level            (i_b_level),
        .i_elapsed_ms         (i_elapsed_ms),
        .i_ir_distance        (i_ir_distance),
        .i_desired_speed      (i_desired_speed),
        .i_turn_rate          (i_turn_rate),
        .i_prop_gain          (r_prop_gain),
        .i_integ_gain         (r_integ_gain),
        .i_obstacle_threshold (r_obstacle_threshold),
        .i_half_track         (r_half_track),
        .i_speed_scale        (r_speed_scale),
        .i_drive_limit        (r_drive_limit),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_left_duty          (o_left_duty),
        .o_left_reverse       (o_left_reverse),
        .o_right_duty         (o_right_duty),
        .o_right_reverse      (o_right_reverse),
        .o_buzzer_on          (o_buzzer_on),
        .o_left_speed         (o_left_speed),
        .o_right_speed        (o_right_speed)
    );

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_mode == MODE_TICK)) |=> o_in_stall)
        else $error("control tick transaction did not occupy the block");

    a_edge_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_mode != MODE_TICK)) |=> !o_in_stall)
        else $error("encoder transaction stalled the input");

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_left_duty <= r_drive_limit) && (o_right_duty <= r_drive_limit)))
        else $error("duty above drive limit");

    a_reverse_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_left_reverse || o_right_reverse)) |->
        ((!o_left_reverse || (o_left_duty != '0)) && (!o_right_reverse || (o_right_duty != '0))))
        else $error("reverse flag set on zero duty");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the differential drive wheel speed PI controller.
`timescale 1ns / 1ps
module tb;
    import dd_pi_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 48;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic                    b_level;
        logic [MS_W-1:0]         elapsed_ms;
        logic [DIST_W-1:0]       ir_distance;
        logic signed [SPD_W-1:0] desired_speed;
        logic signed [SPD_W-1:0] turn_rate;
    } t_wheel_item;

    typedef struct {
        logic [LIM_W-1:0]        left_duty;
        logic                    left_reverse;
        logic [LIM_W-1:0]        right_duty;
        logic                    right_reverse;
        logic                    buzzer_on;
        logic signed [SPD_W-1:0] left_speed;
        logic signed [SPD_W-1:0] right_speed;
    } t_drive_cmd;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [MODE_W-1:0]       i_mode = '0;
    logic                    i_b_level = 1'b0;
    logic [MS_W-1:0]         i_elapsed_ms = '0;
    logic [DIST_W-1:0]       i_ir_distance = '0;
    logic signed [SPD_W-1:0] i_desired_speed = '0;
    logic signed [SPD_W-1:0] i_turn_rate = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [LIM_W-1:0]        o_left_duty;
    logic                    o_left_reverse;
    logic [LIM_W-1:0]        o_right_duty;
    logic                    o_right_reverse;
    logic                    o_buzzer_on;
    logic signed [SPD_W-1:0] o_left_speed;
    logic signed [SPD_W-1:0] o_right_speed;

    // register copies and controller state
    int unsigned cfg_prop       = RST_PROP_GAIN;
    int unsigned cfg_integ      = RST_INTEG_GAIN;
    int unsigned cfg_thresh     = RST_OBST_THRESH;
    int unsigned cfg_half_track = RST_HALF_TRACK;
    int unsigned cfg_scale      = RST_SPEED_SCALE;
    int unsigned cfg_limit      = RST_DRIVE_LIMIT;
    longint left_ticks    = 0;
    longint right_ticks   = 0;
    longint left_err_sum  = 0;
    longint right_err_sum = 0;
    longint left_drive    = 0;
    longint right_drive   = 0;

    t_drive_cmd pending_cmds[$];

    int errors        = 0;
    int cycles        = 0;
    int edges_sent    = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int tx_gap_max    = 10;
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;
    int rx_hold_cycles = 0;

    diff_drive_wheel_pi_controller_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_b_level       (i_b_level),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_ir_distance   (i_ir_distance),
        .i_desired_speed (i_desired_speed),
        .i_turn_rate     (i_turn_rate),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_duty     (o_left_duty),
        .o_left_reverse  (o_left_reverse),
        .o_right_duty    (o_right_duty),
        .o_right_reverse (o_right_reverse),
        .o_buzzer_on     (o_buzzer_on),
        .o_left_speed    (o_left_speed),
        .o_right_speed   (o_right_speed)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit count_error();
        errors++;
        return errors <= 10;
    endfunction

    function automatic longint clip(longint x, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic longint wheel_speed(longint ticks, int unsigned ms);
        longint den;
        if (ms == 0) ms = 1;
        den = longint'(ms) << SPEED_SHIFT;
        return clip((ticks * longint'(cfg_scale)) / den, SPD_W);
    endfunction

    function automatic longint pi_drive(longint setpoint, longint speed,
                                        inout longint sum, inout longint last);
        longint err;
        longint lim;
        longint mag;
        longint u;
        err = setpoint - speed;
        lim = cfg_limit;
        mag = (last < 0) ? -last : last;
        // integrate only while the previous drive was not at the limit
        if (mag < lim) sum = clip(sum + err, SUM_WIDTH);
        u = (longint'(cfg_prop) * err + longint'(cfg_integ) * sum) >>> FRAC_BITS;
        if (u > lim) u = lim;
        if (u < -lim) u = -lim;
        last = u;
        return u;
    endfunction

    function automatic bit step_model(input t_wheel_item it, output t_drive_cmd cmd);
        longint vl;
        longint vr;
        longint v;
        longint half_turn;
        longint ul;
        longint ur;
        logic   buzz;
        cmd = '{default: '0};
        unique case (it.mode)
            MODE_LEFT: begin
                left_ticks = clip(left_ticks + (it.b_level ? 1 : -1), TICK_WIDTH);
                return 1'b0;
            end
            MODE_RIGHT: begin
                right_ticks = clip(right_ticks + (it.b_level ? -1 : 1), TICK_WIDTH);
                return 1'b0;
            end
            MODE_TICK: begin
                vl = wheel_speed(left_ticks, it.elapsed_ms);
                vr = wheel_speed(right_ticks, it.elapsed_ms);
                left_ticks  = 0;
                right_ticks = 0;
                buzz = (it.ir_distance < cfg_thresh) && (it.desired_speed > 0);
                if (buzz) v = 0;
                else v = longint'(it.desired_speed);
                half_turn = (longint'(cfg_half_track) * longint'(it.turn_rate)) >>> FRAC_BITS;
                ul = pi_drive(v - half_turn, vl, left_err_sum, left_drive);
                ur = pi_drive(v + half_turn, vr, right_err_sum, right_drive);
                cmd.left_duty     = LIM_W'((ul < 0) ? -ul : ul);
                cmd.left_reverse  = (ul < 0);
                cmd.right_duty    = LIM_W'((ur < 0) ? -ur : ur);
                cmd.right_reverse = (ur < 0);
                cmd.buzzer_on     = buzz;
                cmd.left_speed    = SPD_W'(vl);
                cmd.right_speed   = SPD_W'(vr);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int unsigned reg_width(logic [REG_W-1:0] idx);
        unique case (idx)
            REG_PROP_GAIN:   return GAIN_W;
            REG_INTEG_GAIN:  return GAIN_W;
            REG_OBST_THRESH: return DIST_W;
            REG_HALF_TRACK:  return HTRK_W;
            REG_SPEED_SCALE: return SCALE_W;
            default:         return LIM_W;
        endcase
    endfunction

    function automatic int unsigned model_reg(logic [REG_W-1:0] idx);
        unique case (idx)
            REG_PROP_GAIN:   return cfg_prop;
            REG_INTEG_GAIN:  return cfg_integ;
            REG_OBST_THRESH: return cfg_thresh;
            REG_HALF_TRACK:  return cfg_half_track;
            REG_SPEED_SCALE: return cfg_scale;
            default:         return cfg_limit;
        endcase
    endfunction

    function automatic t_wheel_item edge_item(logic [MODE_W-1:0] mode, logic b);
        t_wheel_item it;
        it.mode          = mode;
        it.b_level       = b;
        it.elapsed_ms    = MS_W'($urandom);
        it.ir_distance   = DIST_W'($urandom);
        it.desired_speed = SPD_W'($urandom);
        it.turn_rate     = SPD_W'($urandom);
        return it;
    endfunction

    function automatic t_wheel_item tick_item(int unsigned ms, int unsigned ir, int v, int turn);
        t_wheel_item it;
        it = edge_item(MODE_TICK, 1'($urandom_range(0, 1)));
        it.elapsed_ms    = MS_W'(ms);
        it.ir_distance   = DIST_W'(ir);
        it.desired_speed = SPD_W'(v);
        it.turn_rate     = SPD_W'(turn);
        return it;
    endfunction

    function automatic t_wheel_item random_tick();
        int unsigned k;
        int unsigned ms;
        int unsigned ir;
        int          v;
        int          turn;
        k = $urandom_range(0, 9);
        if (k < 5) ms = $urandom_range(1, 200);
        else if (k < 8) ms = $urandom_range(0, 65535);
        else ms = $urandom_range(0, 3);
        ir = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
        if ($urandom_range(0, 9) < 6) v = int'($urandom_range(0, 4000)) - 2000;
        else v = int'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) < 6) turn = int'($urandom_range(0, 16000)) - 8000;
        else turn = int'($urandom_range(0, 65535));
        return tick_item(ms, ir, v, turn);
    endfunction

    task automatic send_item(input t_wheel_item it);
        int         gap;
        bit         has_cmd;
        t_drive_cmd cmd;
        gap = (tx_gap_max == 0 || tx_steady) ? 0 : $urandom_range(0, tx_gap_max);
        if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= it.mode;
        i_b_level       <= it.b_level;
        i_elapsed_ms    <= it.elapsed_ms;
        i_ir_distance   <= it.ir_distance;
        i_desired_speed <= it.desired_speed;
        i_turn_rate     <= it.turn_rate;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        has_cmd = step_model(it, cmd);
        if (has_cmd) begin
            pending_cmds.push_back(cmd);
            ticks_sent++;
        end else if (it.mode != MODE_SPARE) begin
            edges_sent++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic [REG_W-1:0] idx, input logic wr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic verify_reg(input logic [REG_W-1:0] idx);
        logic [DATA_W-1:0] rd;
        int unsigned       mask;
        mask = (32'd1 << reg_width(idx)) - 1;
        apb_access(idx, 1'b0, '0, rd);
        if ((rd & mask) !== model_reg(idx)) begin
            if (count_error())
                $display("tb: register %0d reads %0d, expected %0d", idx, rd & mask, model_reg(idx));
        end
    endtask

    task automatic set_reg(input logic [REG_W-1:0] idx, input int unsigned value);
        logic [DATA_W-1:0] unused_rd;
        int unsigned       v;
        v = value & ((32'd1 << reg_width(idx)) - 1);
        apb_access(idx, 1'b1, value, unused_rd);
        unique case (idx)
            REG_PROP_GAIN:   cfg_prop       = v;
            REG_INTEG_GAIN:  cfg_integ      = v;
            REG_OBST_THRESH: cfg_thresh     = v;
            REG_HALF_TRACK:  cfg_half_track = v;
            REG_SPEED_SCALE: cfg_scale      = v;
            default:         cfg_limit      = v;
        endcase
        verify_reg(idx);
    endtask

    task automatic apply_settings(input int unsigned prop, input int unsigned integ,
                                  input int unsigned thresh, input int unsigned half_track,
                                  input int unsigned scale, input int unsigned limit);
        settle();
        set_reg(REG_PROP_GAIN, prop);
        set_reg(REG_INTEG_GAIN, integ);
        set_reg(REG_OBST_THRESH, thresh);
        set_reg(REG_HALF_TRACK, half_track);
        set_reg(REG_SPEED_SCALE, scale);
        set_reg(REG_DRIVE_LIMIT, limit);
    endtask

    // encoder bursts closed by a control tick, plus lone ticks and unused-mode noise
    task automatic run_traffic(input int n_items);
        int count;
        int n_edges;
        int k;
        bit left_dir;
        bit right_dir;
        bit b;
        count = 0;
        while (count < n_items) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                send_item(edge_item(MODE_SPARE, 1'($urandom_range(0, 1))));
            end else if (k == 1) begin
                send_item(random_tick());
                count++;
            end else begin
                n_edges   = $urandom_range(1, 16);
                left_dir  = 1'($urandom_range(0, 1));
                right_dir = 1'($urandom_range(0, 1));
                repeat (n_edges) begin
                    if ($urandom_range(0, 1) == 0) begin
                        b = ($urandom_range(0, 4) == 0) ? !left_dir : left_dir;
                        send_item(edge_item(MODE_LEFT, b));
                    end else begin
                        b = ($urandom_range(0, 4) == 0) ? !right_dir : right_dir;
                        send_item(edge_item(MODE_RIGHT, b));
                    end
                    count++;
                end
                send_item(random_tick());
                count++;
            end
        end
    endtask

    task automatic test_register_access();
        verify_reg(REG_PROP_GAIN);
        verify_reg(REG_INTEG_GAIN);
        verify_reg(REG_OBST_THRESH);
        verify_reg(REG_HALF_TRACK);
        verify_reg(REG_SPEED_SCALE);
        verify_reg(REG_DRIVE_LIMIT);
    endtask

    task automatic test_encoder_and_tick_cases();
        repeat (3) send_item(edge_item(MODE_LEFT, 1'b1));
        send_item(edge_item(MODE_LEFT, 1'b0));
        repeat (2) send_item(edge_item(MODE_RIGHT, 1'b0));
        send_item(edge_item(MODE_RIGHT, 1'b1));
        send_item(edge_item(MODE_SPARE, 1'b1));
        // zero elapsed time is taken as one millisecond
        send_item(tick_item(0, 1023, 0, 0));
        send_item(tick_item(1, 0, 32767, 32767));
        repeat (2) send_item(edge_item(MODE_LEFT, 1'b1));
        // distance equal to the threshold is not an obstacle
        send_item(tick_item(65535, RST_OBST_THRESH, 32767, -32768));
        send_item(tick_item(200, RST_OBST_THRESH - 1, 1, 0));
        send_item(tick_item(100, 0, -32768, -32768));
        send_item(tick_item(100, 0, 0, 32767));
        send_item(edge_item(MODE_SPARE, 1'b0));
        send_item(tick_item(65535, 1023, 32767, 32767));
        settle();
    endtask

    task automatic test_output_backpressure();
        tx_gap_max = 0;
        rx_hold_cycles = 300;
        repeat (10) send_item(random_tick());
        tx_gap_max = 10;
        settle();
    endtask

    task automatic test_gain_sweep();
        run_traffic(160);
        apply_settings(1023, 1023, 1023, 4095, 65535, 255);
        run_traffic(150);
        // zero drive limit: every drive is zero and nothing integrates
        apply_settings(0, 0, 0, 0, 0, 0);
        run_traffic(120);
        apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 4095), $urandom_range(0, 65535), 1);
        run_traffic(150);
        apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 4095), $urandom_range(0, 65535), $urandom_range(1, 255));
        run_traffic(180);
        apply_settings($urandom_range(0, 400), $urandom_range(0, 200), $urandom_range(0, 100),
                       $urandom_range(0, 4095), $urandom_range(0, 16000), 255);
        run_traffic(180);
    endtask

    // result side: random stall per transaction, long hold when asked
    initial begin : result_stall
        int w;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
            w = rx_steady ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (o_out_valid !== 1'b1);
                repeat (w - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_drive_cmd want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (pending_cmds.size() == 0) begin
                if (count_error())
                    $display("tb: unexpected result duty %0d/%0d", o_left_duty, o_right_duty);
            end else begin
                want = pending_cmds.pop_front();
                if (o_left_duty !== want.left_duty || o_left_reverse !== want.left_reverse ||
                    o_right_duty !== want.right_duty || o_right_reverse !== want.right_reverse ||
                    o_buzzer_on !== want.buzzer_on || o_left_speed !== want.left_speed ||
                    o_right_speed !== want.right_speed) begin
                    if (count_error()) begin
                        $display("tb: mismatch exp L %0d/%0b R %0d/%0b bz %0b v %0d %0d",
                                 want.left_duty, want.left_reverse, want.right_duty,
                                 want.right_reverse, want.buzzer_on, want.left_speed,
                                 want.right_speed);
                        $display("tb:          got L %0d/%0b R %0d/%0b bz %0b v %0d %0d",
                                 o_left_duty, o_left_reverse, o_right_duty, o_right_reverse,
                                 o_buzzer_on, o_left_speed, o_right_speed);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results pending", cycles,
                     pending_cmds.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_encoder_and_tick_cases();
        test_output_backpressure();
        test_gain_sweep();
        settle();
        if (pending_cmds.size() != 0) begin
            if (count_error()) $display("tb: %0d results never arrived", pending_cmds.size());
        end
        $display("tb: %0d encoder edges, %0d control ticks, %0d results checked",
                 edges_sent, ticks_sent, results_seen);
        $display("tb: covered speed clipping, obstacle override, register extremes, backpressure");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
